// ===== hdl/soc_pkg.sv =====
// types and constants shared by the substring occurrence counter
// no dependencies; used by soc_cell, soc_count and substring_occurrence_counter
`default_nettype none

package soc_pkg;

   localparam int BYTE_BITS    = 8;
   localparam int PATTERN_BITS = 64;
   localparam int LEN_BITS     = 4;
   localparam int SEEN_BITS    = 4;
   localparam int HOLD_BITS    = 3;
   localparam int OUT_BITS     = 16;
   localparam int ADDR_BITS    = 4;
   localparam int DATA_BITS    = 64;

   // register index, taken from paddr bit 3 (registers lie 8 bytes apart)
   typedef enum logic {
      REG_PATTERN = 1'b0,
      REG_LENGTH  = 1'b1
   } reg_index_type;

   // per-word control handed from the window chain to the counter
   typedef struct packed {
      logic accept;
      logic last;
      logic window_hit;
   } step_type;

endpackage : soc_pkg

`default_nettype wire

// ===== hdl/soc_cell.sv =====
// one byte cell of the text window chain: holds a byte and compares its next value
// depends on soc_pkg
`default_nettype none

module soc_cell (
   input  wire logic                           clock,
   input  wire logic                           shift_en,
   input  wire logic [soc_pkg::BYTE_BITS-1:0]  shift_in,
   input  wire logic [soc_pkg::BYTE_BITS-1:0]  pat_byte,
   input  wire logic                           used,
   output logic      [soc_pkg::BYTE_BITS-1:0]  data_out,
   output logic                                match_ok
);
   import soc_pkg::*;

   logic [BYTE_BITS-1:0] data_ff;
   logic [BYTE_BITS-1:0] data_in;

   assign data_in  = shift_en ? shift_in : data_ff;
   // compare against the byte this cell takes on this word
   assign match_ok = !used || (shift_in == pat_byte);
   assign data_out = data_ff;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule : soc_cell

`default_nettype wire

// ===== hdl/soc_count.sv =====
// text byte count, hold-off and saturating hit counter
// depends on soc_pkg
`default_nettype none

module soc_count #(
   parameter int MAX_PATTERN = 8,
   parameter int COUNT_BITS  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire soc_pkg::step_type             step,
   input  wire logic [soc_pkg::LEN_BITS-1:0]  len,
   output logic      [soc_pkg::OUT_BITS-1:0]  total_out
);
   import soc_pkg::*;

   localparam int WIDE_BITS = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
   localparam logic [SEEN_BITS-1:0]  SEEN_MAX  = SEEN_BITS'(MAX_PATTERN);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [WIDE_BITS-1:0]  OUT_MAX   = WIDE_BITS'({OUT_BITS{1'b1}});

   logic [SEEN_BITS-1:0]  seen_ff,  seen_in,  seen_next;
   logic [HOLD_BITS-1:0]  hold_ff,  hold_in,  hold_next;
   logic [COUNT_BITS-1:0] total_ff, total_in, total_next;
   logic [WIDE_BITS-1:0]  total_wide;

   always_comb begin
      seen_next  = (seen_ff == SEEN_MAX) ? seen_ff : seen_ff + 1'b1;
      hold_next  = hold_ff;
      total_next = total_ff;
      if (hold_ff != '0) begin
         hold_next = hold_ff - 1'b1;
      end else if (step.window_hit && (seen_next >= len)) begin
         if (total_ff != COUNT_MAX) begin
            total_next = total_ff + 1'b1;
         end
         hold_next = HOLD_BITS'(len - 1'b1);
      end

      seen_in  = seen_ff;
      hold_in  = hold_ff;
      total_in = total_ff;
      if (step.accept) begin
         if (step.last) begin
            seen_in  = '0;
            hold_in  = '0;
            total_in = '0;
         end else begin
            seen_in  = seen_next;
            hold_in  = hold_next;
            total_in = total_next;
         end
      end

      total_wide = WIDE_BITS'(total_next);
      total_out  = (total_wide > OUT_MAX) ? OUT_BITS'(OUT_MAX) : total_wide[OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         hold_ff  <= '0;
         total_ff <= '0;
      end else begin
         seen_ff  <= seen_in;
         hold_ff  <= hold_in;
         total_ff <= total_in;
      end
   end

endmodule : soc_count

`default_nettype wire

// ===== hdl/substring_occurrence_counter.sv =====
// top level of the substring occurrence counter
// depends on soc_pkg, soc_cell and soc_count
`default_nettype none

// Counts non-overlapping occurrences of a pattern of 1 to MAX_PATTERN bytes in a
// text that arrives one byte per word on the req channel. Hits are taken greedily
// left to right: after a hit the next pattern_length-1 bytes cannot end another.
// On the word marked end_of_text one rsp word carries the hit total of that text
// (hits ending on the last byte included, saturating at 65535) and all per-text
// state clears, so the next word starts a new text. One word per cycle is taken:
// a row of MAX_PATTERN byte cells shifts the text along and every cell compares
// its incoming byte against its pattern byte in parallel, so words may arrive
// back to back. Words that are not marked last are always taken; a last word is
// held off only while a previous total still waits on a stalled rsp channel.
// Registers (64-bit APB port): pattern_bytes at 0x0, first pattern byte in bits
// 7..0; pattern_length at 0x8, a length of zero acts as one and a length above
// MAX_PATTERN acts as MAX_PATTERN. Write registers only while the block is idle.
module substring_occurrence_counter #(
   parameter int MAX_PATTERN = 8,
   parameter int COUNT_BITS  = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // text words
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [soc_pkg::BYTE_BITS-1:0]   req_text_byte,
   input  wire logic                            req_end_of_text,
   // totals
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [soc_pkg::OUT_BITS-1:0]    rsp_occurrence_total,
   // register port
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [soc_pkg::ADDR_BITS-1:0]   paddr,
   input  wire logic [soc_pkg::DATA_BITS-1:0]   pwdata,
   output logic      [soc_pkg::DATA_BITS-1:0]   prdata,
   output logic                                 pready
);
   import soc_pkg::*;

   localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_PATTERN);

   // configuration registers
   logic [PATTERN_BITS-1:0] pattern_ff, pattern_in;
   logic [LEN_BITS-1:0]     length_ff,  length_in;
   reg_index_type           reg_sel;
   logic                    reg_write;

   // datapath
   logic [LEN_BITS-1:0]     len;
   logic                    accept;
   logic [BYTE_BITS-1:0]    cell_data [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]  cell_ok;
   step_type                step;
   logic [OUT_BITS-1:0]     total_out;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]     rsp_total_ff, rsp_total_in;

   // ---------------- register port ----------------
   assign pready    = 1'b1;
   assign reg_sel   = reg_index_type'(paddr[3]);
   assign reg_write = psel && penable && pwrite;

   always_comb begin
      pattern_in = pattern_ff;
      length_in  = length_ff;
      prdata     = '0;
      unique case (reg_sel)
         REG_PATTERN: begin
            prdata = pattern_ff;
            if (reg_write) begin
               pattern_in = pwdata;
            end
         end
         REG_LENGTH: begin
            prdata = DATA_BITS'(length_ff);
            if (reg_write) begin
               length_in = pwdata[LEN_BITS-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= LEN_BITS'(1);
      end else begin
         pattern_ff <= pattern_in;
         length_ff  <= length_in;
      end
   end

   // effective pattern length, clamped to 1..MAX_PATTERN
   always_comb begin
      if (length_ff == '0) begin
         len = LEN_BITS'(1);
      end else if (length_ff > LEN_MAX) begin
         len = LEN_MAX;
      end else begin
         len = length_ff;
      end
   end

   // ---------------- handshake ----------------
   // only a word that produces a total has to wait for the result register
   assign req_stall = rsp_valid_ff && rsp_stall && req_end_of_text;
   assign accept    = req_valid && !req_stall;

   // ---------------- window chain ----------------
   // cell k holds the byte k places back from the newest; it is matched
   // against pattern byte len-1-k when k < len
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      localparam logic [LEN_BITS-1:0] K_POS = LEN_BITS'(k);
      logic [BYTE_BITS-1:0] shift_in;
      logic [2:0]           pat_idx;
      logic [LEN_BITS-1:0]  pat_pos;

      if (k == 0) begin : g_head
         assign shift_in = req_text_byte;
      end else begin : g_link
         assign shift_in = cell_data[k-1];
      end

      assign pat_pos = len - 1'b1 - K_POS;
      assign pat_idx = pat_pos[2:0];

      soc_cell u_cell (
         .clock    (clock),
         .shift_en (accept),
         .shift_in (shift_in),
         .pat_byte (pattern_ff[BYTE_BITS*pat_idx +: BYTE_BITS]),
         .used     (K_POS < len),
         .data_out (cell_data[k]),
         .match_ok (cell_ok[k])
      );
   end

   assign step.accept     = accept;
   assign step.last       = req_end_of_text;
   assign step.window_hit = &cell_ok;

   // ---------------- counters ----------------
   soc_count #(
      .MAX_PATTERN (MAX_PATTERN),
      .COUNT_BITS  (COUNT_BITS)
   ) u_count (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .len       (len),
      .total_out (total_out)
   );

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_total_in = rsp_total_ff;
      if (accept && req_end_of_text) begin
         rsp_valid_in = 1'b1;
         rsp_total_in = total_out;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_occurrence_total = rsp_total_ff;

endmodule : substring_occurrence_counter

`default_nettype wire
